// File: sv/positional_sequence_range_sum_assert.svh
// Assertion macros used by the sequence store top level.
`ifndef POSITIONAL_SEQUENCE_RANGE_SUM_ASSERT_SVH
`define POSITIONAL_SEQUENCE_RANGE_SUM_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define PSRS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psrs: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define PSRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psrs: next-cycle check failed");

`endif

// File: sv/psrs_pkg.sv
// Shared types and codes for the positional sequence store.
package psrs_pkg;

  localparam int TOTAL_W = 42;

  // Operation codes.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SUM    = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] position;
    logic [31:0] value;
    logic [9:0]  first;
    logic [9:0]  last;
  } req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [1:0]         status;
  } rsp_t;

  // A finished result offered by the sequencer.
  typedef struct packed {
    logic valid;
    rsp_t data;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

endpackage

// File: sv/psrs_chan_if.sv
// Valid/ready channel carrying one request or response payload.
interface psrs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// File: sv/psrs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module psrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/psrs_seq.sv
// Sequencer that shifts, fills and sums entries of the sequence memory.
module psrs_seq #(
  parameter int CAPACITY = 1024,
  parameter int VALUE_BITS = 32,
  localparam int LenW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  psrs_pkg::req_t     cmd,
  output logic               idle,
  output psrs_pkg::result_t  res,
  input  logic               res_take,
  output logic [LenW-1:0]    len
);
  import psrs_pkg::*;

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CmpW  = (LenW > 11) ? LenW : 11;

  state_t                state, state_next;
  logic [1:0]            op;
  logic [VALUE_BITS-1:0] val_q;
  logic [AddrW-1:0]      rd_ptr, wr_ptr;
  logic [LenW-1:0]       remain, gap;
  logic                  pend;
  logic [TOTAL_W-1:0]    acc;
  logic [1:0]            status;

  logic [CmpW-1:0] len_c, pos_c, lo_c, hi_c, ins_p, sum_hi;
  logic            full, del_bad, sum_none, finish;

  logic                  mem_we, mem_re;
  logic [AddrW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

  psrs_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Decode of the incoming request against the current length.
  always_comb begin
    len_c    = CmpW'(len);
    pos_c    = CmpW'(cmd.position);
    lo_c     = CmpW'(cmd.first);
    hi_c     = CmpW'(cmd.last);
    ins_p    = (pos_c > len_c) ? len_c : pos_c;
    full     = (len_c == CmpW'(CAPACITY));
    del_bad  = (lo_c > hi_c) || (hi_c >= len_c);
    sum_hi   = (hi_c >= len_c) ? (len_c - CmpW'(1)) : hi_c;
    sum_none = (len == '0) || (lo_c > sum_hi);
    finish   = (remain == '0) && !pend;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.func)
            FUNC_INSERT: state_next = full ? S_DONE : S_RUN;
            FUNC_DELETE: state_next = del_bad ? S_DONE : S_RUN;
            FUNC_SUM:    state_next = S_RUN;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_RUN: begin
        if (finish) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control and result outputs.
  always_comb begin
    mem_re    = (state == S_RUN) && (remain != '0);
    mem_raddr = rd_ptr;
    mem_we    = (state == S_RUN) &&
                ((pend && (op != FUNC_SUM)) || (finish && (op == FUNC_INSERT)));
    mem_waddr = wr_ptr;
    mem_wdata = pend ? mem_rdata : val_q;
    idle      = (state == S_IDLE);
    res.valid       = (state == S_DONE);
    res.data.total  = acc;
    res.data.status = status;
  end

  // Control state: FSM, length and the read-pending flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        pend <= (remain != '0);
        if (finish) begin
          if (op == FUNC_INSERT) begin
            len <= len + LenW'(1);
          end else if (op == FUNC_DELETE) begin
            len <= len - gap;
          end
        end
      end else begin
        pend <= 1'b0;
      end
    end
  end

  // Datapath: pointers, move counter and accumulator.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      op     <= cmd.func;
      val_q  <= VALUE_BITS'(cmd.value);
      acc    <= '0;
      status <= STATUS_OK;
      unique case (cmd.func)
        FUNC_INSERT: begin
          // Entries from the end down to the insert point move up by one.
          rd_ptr <= AddrW'(len_c - CmpW'(1));
          wr_ptr <= AddrW'(len_c);
          remain <= LenW'(len_c - ins_p);
          if (full) begin
            status <= STATUS_FULL;
          end
        end
        FUNC_DELETE: begin
          // Entries after the range move down by the range length.
          rd_ptr <= AddrW'(hi_c + CmpW'(1));
          wr_ptr <= AddrW'(lo_c);
          remain <= LenW'(len_c - hi_c - CmpW'(1));
          gap    <= LenW'(hi_c - lo_c + CmpW'(1));
          if (del_bad) begin
            status <= STATUS_BAD_RANGE;
          end
        end
        FUNC_SUM: begin
          rd_ptr <= AddrW'(lo_c);
          remain <= sum_none ? '0 : LenW'(sum_hi - lo_c + CmpW'(1));
        end
        default: ;
      endcase
    end else if (state == S_RUN) begin
      // Issue one read per cycle while entries remain.
      if (remain != '0) begin
        remain <= remain - LenW'(1);
        rd_ptr <= (op == FUNC_INSERT) ? rd_ptr - AddrW'(1) : rd_ptr + AddrW'(1);
      end
      // Consume the data read in the previous cycle.
      if (pend) begin
        if (op == FUNC_SUM) begin
          acc <= acc + TOTAL_W'(mem_rdata);
        end else begin
          wr_ptr <= (op == FUNC_INSERT) ? wr_ptr - AddrW'(1) : wr_ptr + AddrW'(1);
        end
      end
    end
  end

endmodule

// File: sv/positional_sequence_range_sum.sv
// Top level of the positional sequence store with range delete and range sum.
//
//   channel | dir | payload                                 | accepted when
//   req     | in  | func, position, value, first, last      | valid && ready
//   rsp     | out | total, status                           | valid && ready
//
// One request is worked at a time; ready is high only while the sequencer is idle.
// The response is offered once the sequencer has moved or read its entries: an insert
// moves length - position entries, a delete length - last - 1, a sum reads its
// clipped range. A rejected request goes straight to the done state without moving
// entries; operation code 3 gives no response.
// Reset empties the sequence, leaves memory as is; a stalled response waits in the
// output register while the next request is taken.
`include "positional_sequence_range_sum_assert.svh"

module positional_sequence_range_sum #(
  parameter int CAPACITY = 1024,
  parameter int VALUE_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  psrs_chan_if.sink   req,
  psrs_chan_if.source rsp
);
  import psrs_pkg::*;

  localparam int LenW = $clog2(CAPACITY + 1);

  logic            start, eng_idle, res_take;
  result_t         eng_res;
  logic [LenW-1:0] eng_len;
  logic            out_valid;
  rsp_t            out_data;

  psrs_seq #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (req.payload),
    .idle    (eng_idle),
    .res     (eng_res),
    .res_take(res_take),
    .len     (eng_len)
  );

  // Request side; nothing is taken while reset is held.
  assign req.ready = eng_idle && !rst;
  assign start     = req.valid && req.ready;

  // The output register takes a result whenever it is empty or being drained.
  assign res_take = eng_res.valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= eng_res.data;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  // Checks on the sequencer and output register.
  `PSRS_ASSERT_IMPLY(a_len_in_capacity, 1'b1, eng_len <= LenW'(CAPACITY))
  `PSRS_ASSERT_IMPLY(a_reject_zero_total, eng_res.valid && (eng_res.data.status != STATUS_OK),
                     eng_res.data.total == '0)
  `PSRS_ASSERT_NEXT(a_unknown_op_silent,
                    start && (req.payload.func != FUNC_INSERT) &&
                    (req.payload.func != FUNC_DELETE) && (req.payload.func != FUNC_SUM),
                    !eng_res.valid && eng_idle)
  `PSRS_ASSERT_NEXT(a_take_fills_output, res_take, out_valid)

endmodule
